FILE: sv/rrr_pkg.sv
`timescale 1ns / 1ps

package rrr_pkg;

    // Defaults and fixed widths
    localparam int NUM_REGS_DEF = 7;
    localparam int REQ_KEEP     = 6;
    localparam int REG_INDEX_W  = 3;
    localparam int REG_VALUE_W  = 16;
    localparam int BYTE_W       = 8;

    // CRC-16/Modbus, reflected form
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Function codes answered
    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;

    // Request operation codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Address after reset
    localparam logic [7:0] ADDR_RESET = 8'h01;

    typedef struct packed {
        logic                   op;
        logic [BYTE_W-1:0]      frame_byte;
        logic                   frame_end;
        logic [REG_INDEX_W-1:0] reg_index;
        logic [REG_VALUE_W-1:0] reg_value;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] resp_byte;
        logic              resp_last;
    } out_item_t;

endpackage

FILE: sv/register_read_responder_core.sv
`timescale 1ns / 1ps

// Register read responder: a Modbus RTU style slave that answers function 3
// and 4 (read registers) requests from a small local register file. Requests
// arrive one per handshake: either a frame byte (op 0) or a local register
// write (op 1). The first six bytes of each frame are kept; on the byte that
// carries frame_end the frame is checked (address against slave_address,
// function 3 or 4, start + count not past NUM_REGS as a 17-bit sum) and, if it
// passes, the response is sent one byte per output handshake: address,
// function, byte count, each register high then low byte, then the CRC low
// and high byte, with resp_last on the final byte. Short frames, bad
// frames and frames out of range get no response; the request CRC is not
// checked. The top register always reads zero. A frame byte or a register
// write is taken without holding off the next request. A frame end after six
// or more bytes holds off further requests while the frame is checked in
// S_CHECK; if it produces a response, the hold-off lasts until the CRC high
// byte is in the output register, with any output stall. Header and data
// bytes pass S_LOAD, S_SHIFT and S_PUT, CRC bytes S_LOAD and S_PUT; the CRC
// is built one bit per cycle in an 8-bit shift register. The last response
// byte sits in the output register, so new requests are taken while it waits.
module register_read_responder_core #(
    parameter int NUM_REGS = rrr_pkg::NUM_REGS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  rrr_pkg::in_item_t in_data,
    // response channel
    output logic              out_valid,
    input  logic              out_stall,
    output rrr_pkg::out_item_t out_data,
    // slave address write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    // Only indices reachable through reg_index and below the top register
    // are ever written; the rest read as zero and need no storage.
    localparam int IDX_SPAN = 2 ** rrr_pkg::REG_INDEX_W;
    localparam int WR_REGS  = (NUM_REGS - 1 < IDX_SPAN) ? NUM_REGS - 1 : IDX_SPAN;
    localparam int IDX_W    = (WR_REGS > 1) ? $clog2(WR_REGS) : 1;
    localparam int PTR_W    = $clog2(NUM_REGS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_SHIFT,
        S_PUT
    } state_t;

    // which response byte is being worked on
    typedef enum logic [2:0] {
        B_ADDR,
        B_FUNC,
        B_BCNT,
        B_DHI,
        B_DLO,
        B_CRCLO,
        B_CRCHI
    } sel_t;

    state_t                          state_reg, state_next;
    sel_t                            sel_reg, sel_next;
    logic [2:0]                      pos_reg, pos_next;
    logic [PTR_W-1:0]                ptr_reg, ptr_next;
    logic [PTR_W-1:0]                left_reg, left_next;
    logic [7:0]                      sh_reg, sh_next;
    logic [7:0]                      cur_reg, cur_next;
    logic [2:0]                      bit_cnt_reg, bit_cnt_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [7:0]                      addr_reg, addr_next;
    logic                            out_valid_reg, out_valid_next;
    rrr_pkg::out_item_t              out_data_reg, out_data_next;
    logic [rrr_pkg::REG_VALUE_W-1:0] rf_reg [WR_REGS];
    logic [7:0]                      req_reg [rrr_pkg::REQ_KEEP];

    logic        in_fire;
    logic        out_free;
    logic        rf_we;
    logic        req_we;
    logic [15:0] start_w;
    logic [15:0] count_w;
    logic [16:0] range_end;
    logic        frame_ok;
    logic [15:0] rd_value;
    logic [7:0]  load_byte;
    logic        crc_fb;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign rf_we  = in_fire && (in_data.op == rrr_pkg::OP_WRITE) &&
                    ({1'b0, in_data.reg_index} < (rrr_pkg::REG_INDEX_W + 1)'(WR_REGS));
    assign req_we = in_fire && (in_data.op == rrr_pkg::OP_FRAME) &&
                    (pos_reg < 3'(rrr_pkg::REQ_KEEP));

    // Frame check, all six bytes are present once in S_CHECK
    assign start_w   = {req_reg[2], req_reg[3]};
    assign count_w   = {req_reg[4], req_reg[5]};
    assign range_end = {1'b0, start_w} + {1'b0, count_w};
    assign frame_ok  = (req_reg[0] == addr_reg) &&
                       ((req_reg[1] == rrr_pkg::FN_READ_HOLDING) ||
                        (req_reg[1] == rrr_pkg::FN_READ_INPUT)) &&
                       (range_end <= 17'(NUM_REGS));

    // Register read at the current pointer; unstored registers read zero
    always_comb
    begin
        rd_value = '0;
        if (ptr_reg < PTR_W'(WR_REGS))
        begin
            rd_value = rf_reg[ptr_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        case (sel_reg)
            B_ADDR:  load_byte = addr_reg;
            B_FUNC:  load_byte = req_reg[1];
            B_BCNT:  load_byte = {req_reg[5][6:0], 1'b0};
            B_DHI:   load_byte = rd_value[15:8];
            B_DLO:   load_byte = rd_value[7:0];
            B_CRCLO: load_byte = crc_reg[7:0];
            B_CRCHI: load_byte = crc_reg[15:8];
            default: load_byte = '0;
        endcase
    end

    assign crc_fb = crc_reg[0] ^ sh_reg[0];

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        sh_next        = sh_reg;
        cur_next       = cur_reg;
        bit_cnt_next   = bit_cnt_reg;
        crc_next       = crc_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // drop the output once taken; S_PUT may reload it below
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            addr_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_data.op == rrr_pkg::OP_FRAME))
                begin
                    if (pos_reg < 3'(rrr_pkg::REQ_KEEP))
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    if (in_data.frame_end)
                    begin
                        pos_next = '0;
                        // full once the sixth byte lands in this request
                        if (pos_reg >= 3'(rrr_pkg::REQ_KEEP - 1))
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end

            S_CHECK:
            begin
                if (frame_ok)
                begin
                    ptr_next   = start_w[PTR_W-1:0];
                    left_next  = count_w[PTR_W-1:0];
                    crc_next   = rrr_pkg::CRC_INIT;
                    sel_next   = B_ADDR;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_LOAD:
            begin
                sh_next      = load_byte;
                cur_next     = load_byte;
                bit_cnt_next = '0;
                if ((sel_reg == B_CRCLO) || (sel_reg == B_CRCHI))
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // one CRC bit per cycle
                crc_next     = {1'b0, crc_reg[15:1]} ^ (crc_fb ? rrr_pkg::CRC_POLY : 16'h0000);
                sh_next      = {1'b0, sh_reg[7:1]};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    bit_cnt_next = '0;
                    state_next   = S_PUT;
                end
            end

            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.resp_byte = cur_reg;
                    out_data_next.resp_last = (sel_reg == B_CRCHI);
                    state_next              = S_LOAD;
                    unique case (sel_reg)
                        B_ADDR:  sel_next = B_FUNC;
                        B_FUNC:  sel_next = B_BCNT;
                        B_BCNT:  sel_next = (left_reg != '0) ? B_DHI : B_CRCLO;
                        B_DHI:   sel_next = B_DLO;
                        B_DLO:
                        begin
                            ptr_next  = ptr_reg + PTR_W'(1);
                            left_next = left_reg - PTR_W'(1);
                            sel_next  = (left_reg == PTR_W'(1)) ? B_CRCLO : B_DHI;
                        end
                        B_CRCLO: sel_next = B_CRCHI;
                        B_CRCHI:
                        begin
                            sel_next   = B_ADDR;
                            state_next = S_IDLE;
                        end
                        default: sel_next = B_ADDR;
                    endcase
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= B_ADDR;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            bit_cnt_reg   <= '0;
            addr_reg      <= rrr_pkg::ADDR_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int i = 0; i < WR_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            pos_reg       <= pos_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            bit_cnt_reg   <= bit_cnt_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (rf_we)
            begin
                rf_reg[in_data.reg_index[IDX_W-1:0]] <= in_data.reg_value;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        cur_reg      <= cur_next;
        crc_reg      <= crc_next;
        if (req_we)
        begin
            req_reg[pos_reg] <= in_data.frame_byte;
        end
    end

    // The register walk never leaves the range accepted by the frame check
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOAD) || (state_reg == S_SHIFT) || (state_reg == S_PUT)) |->
        (({1'b0, ptr_reg} + {1'b0, left_reg}) <= (PTR_W + 1)'(NUM_REGS)))
    else $error("register walk out of range");

    // The bit counter only runs inside the shifter
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SHIFT) |-> (bit_cnt_reg == 3'd0))
    else $error("bit counter running outside shift");

    // A byte waiting for a stalled output register is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PUT) && out_valid_reg && out_stall) |=>
        ((state_reg == S_PUT) && $stable(cur_reg) && $stable(sel_reg)))
    else $error("response byte advanced past a stalled output");

endmodule
